// ----- sv/tzifp_pkg.sv -----
// shared types and constants for the tzif v1 stream parser
`default_nettype none

package tzifp_pkg;

	localparam int DEF_MAX_TRANSITIONS = 1024;
	localparam int DEF_MAX_TYPES       = 256;
	localparam int DEF_MAX_ABBR_CHARS  = 256;

	localparam int WORD_W  = 32;
	localparam int SKIP_W  = 36;
	localparam int POS_W   = 6;
	localparam int LANE_W  = 3;
	localparam int INDEX_W = 10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] KIND_TIME    = 3'd0;
	localparam logic [2:0] KIND_TTYPE   = 3'd1;
	localparam logic [2:0] KIND_TINFO   = 3'd2;
	localparam logic [2:0] KIND_ABBR    = 3'd3;
	localparam logic [2:0] KIND_VERDICT = 3'd4;

	localparam logic [7:0] MAGIC [4] = '{8'h54, 8'h5A, 8'h69, 8'h66};
	localparam logic [7:0] VER_1 = 8'h00;
	localparam logic [7:0] VER_2 = 8'h32;
	localparam logic [7:0] VER_3 = 8'h33;
	localparam logic [7:0] VER_4 = 8'h34;

	localparam logic [POS_W-1:0] POS_MAGIC_END = 6'd4;
	localparam logic [POS_W-1:0] POS_VERSION   = 6'd4;
	localparam logic [POS_W-1:0] POS_COUNTS    = 6'd20;
	localparam logic [POS_W-1:0] POS_ISUT_END  = 6'd23;
	localparam logic [POS_W-1:0] POS_ISSTD_END = 6'd27;
	localparam logic [POS_W-1:0] POS_LEAP_END  = 6'd31;
	localparam logic [POS_W-1:0] POS_TIME_END  = 6'd35;
	localparam logic [POS_W-1:0] POS_TYPE_END  = 6'd39;
	localparam logic [POS_W-1:0] POS_HDR_LAST  = 6'd43;

	localparam logic [LANE_W-1:0] LANE_TIME_LAST = 3'd3;
	localparam logic [LANE_W-1:0] LANE_TINFO_DST = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]         record_kind;
		logic [9:0]         entry_index;
		logic signed [31:0] time_or_offset;
		logic [7:0]         type_ref;
		logic               is_dst;
		logic [7:0]         abbr_char;
		logic               accepted;
		logic [10:0]        transition_total;
		logic [8:0]         type_total;
		logic [8:0]         abbr_total;
		logic               run_end;
	} result_t;

	typedef struct packed {
		logic    first_valid;
		result_t first;
		logic    second_valid;
		result_t second;
	} push_t;

endpackage

`default_nettype wire

// ----- sv/tzifp_parse.sv -----
// input register, parse state and record formation for one byte per cycle while the result queue has room
`default_nettype none

module tzifp_parse #(
	parameter int MAX_TRANSITIONS = tzifp_pkg::DEF_MAX_TRANSITIONS,
	parameter int MAX_TYPES       = tzifp_pkg::DEF_MAX_TYPES,
	parameter int MAX_ABBR_CHARS  = tzifp_pkg::DEF_MAX_ABBR_CHARS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire tzifp_pkg::item_t item,
	output logic                  item_stall,
	input  wire logic             room,
	output tzifp_pkg::push_t      push
);
	import tzifp_pkg::*;

	localparam int CNT_MAX_TT = (MAX_TRANSITIONS > MAX_TYPES) ? MAX_TRANSITIONS : MAX_TYPES;
	localparam int CNT_MAX = (CNT_MAX_TT > MAX_ABBR_CHARS) ? CNT_MAX_TT : MAX_ABBR_CHARS;
	localparam int CNT_W = $clog2(CNT_MAX + 1);

	typedef enum logic [2:0] {
		SEC_HEADER,
		SEC_TIMES,
		SEC_TTYPES,
		SEC_TINFO,
		SEC_ABBR,
		SEC_SKIP,
		SEC_DONE
	} sec_t;

	logic              valid_s1;
	item_t             item_s1;
	logic              advance;

	sec_t              sec_q, sec_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [WORD_W-1:0] word_q, word_d;
	logic [WORD_W-1:0] tcnt_q, tcnt_d;
	logic [WORD_W-1:0] kcnt_q, kcnt_d;
	logic [WORD_W-1:0] ccnt_q, ccnt_d;
	logic [SKIP_W-1:0] skip_q, skip_d;
	logic [CNT_W-1:0]  ent_q, ent_d;
	logic [LANE_W-1:0] lane_q, lane_d;
	logic              dst_q, dst_d;
	logic              rej_q, rej_d;

	logic [7:0]        b;
	logic              fin;
	logic [WORD_W-1:0] shifted;
	logic [CNT_W-1:0]  ent_inc;
	logic              body_v;
	result_t           body_r;
	result_t           verdict_r;
	logic              ok;

	assign advance    = valid_s1 && room;
	assign item_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		sec_d   = sec_q;
		pos_d   = pos_q;
		word_d  = word_q;
		tcnt_d  = tcnt_q;
		kcnt_d  = kcnt_q;
		ccnt_d  = ccnt_q;
		skip_d  = skip_q;
		ent_d   = ent_q;
		lane_d  = lane_q;
		dst_d   = dst_q;
		rej_d   = rej_q;
		body_v  = 1'b0;
		body_r  = '0;
		b       = item_s1.data_byte;
		fin     = item_s1.final_byte;
		shifted = {word_q[WORD_W-9:0], b};
		ent_inc = ent_q + 1'b1;

		body_r.entry_index = INDEX_W'(ent_q);
		body_r.run_end     = !fin;

		if (!rej_q) begin
			unique case (sec_q)
				SEC_HEADER: begin
					if (pos_q < POS_MAGIC_END && b != MAGIC[pos_q[1:0]]) begin
						rej_d = 1'b1;
					end
					if (pos_q == POS_VERSION && b != VER_1 && b != VER_2 &&
					    b != VER_3 && b != VER_4) begin
						rej_d = 1'b1;
					end
					word_d = shifted;
					if (pos_q >= POS_COUNTS && pos_q[1:0] == 2'd3) begin
						unique case (pos_q)
							POS_ISUT_END:  skip_d = SKIP_W'(shifted);
							POS_ISSTD_END: skip_d = skip_q + SKIP_W'(shifted);
							POS_LEAP_END:  skip_d = skip_q + {1'b0, shifted, 3'b000};
							POS_TIME_END:  tcnt_d = shifted;
							POS_TYPE_END:  kcnt_d = shifted;
							default:       ccnt_d = shifted;
						endcase
					end
					pos_d = pos_q + 1'b1;
					if (pos_q == POS_HDR_LAST && !rej_d) begin
						if (tcnt_q > WORD_W'(MAX_TRANSITIONS) || kcnt_q == '0 ||
						    kcnt_q > WORD_W'(MAX_TYPES) ||
						    shifted > WORD_W'(MAX_ABBR_CHARS)) begin
							rej_d = 1'b1;
						end else begin
							ent_d  = '0;
							lane_d = '0;
							sec_d  = (tcnt_q != '0) ? SEC_TIMES : SEC_TINFO;
						end
					end
				end
				SEC_TIMES: begin
					word_d = shifted;
					if (lane_q == LANE_TIME_LAST) begin
						body_v                = 1'b1;
						body_r.record_kind    = KIND_TIME;
						body_r.time_or_offset = $signed(shifted);
						lane_d                = '0;
						ent_d                 = ent_inc;
						if (WORD_W'(ent_inc) >= tcnt_q) begin
							ent_d = '0;
							sec_d = SEC_TTYPES;
						end
					end else begin
						lane_d = lane_q + 1'b1;
					end
				end
				SEC_TTYPES: begin
					if (WORD_W'(b) >= kcnt_q) begin
						rej_d = 1'b1;
					end else begin
						body_v             = 1'b1;
						body_r.record_kind = KIND_TTYPE;
						body_r.type_ref    = b;
						ent_d              = ent_inc;
						if (WORD_W'(ent_inc) >= tcnt_q) begin
							ent_d  = '0;
							lane_d = '0;
							sec_d  = SEC_TINFO;
						end
					end
				end
				SEC_TINFO: begin
					if (lane_q < LANE_TINFO_DST) begin
						word_d = shifted;
						lane_d = lane_q + 1'b1;
					end else if (lane_q == LANE_TINFO_DST) begin
						dst_d  = (b != 8'd0);
						lane_d = lane_q + 1'b1;
					end else if (WORD_W'(b) >= ccnt_q) begin
						rej_d = 1'b1;
					end else begin
						body_v                = 1'b1;
						body_r.record_kind    = KIND_TINFO;
						body_r.time_or_offset = $signed(word_q);
						body_r.type_ref       = b;
						body_r.is_dst         = dst_q;
						lane_d                = '0;
						ent_d                 = ent_inc;
						if (WORD_W'(ent_inc) >= kcnt_q) begin
							ent_d = '0;
							if (ccnt_q != '0) begin
								sec_d = SEC_ABBR;
							end else begin
								sec_d = (skip_q != '0) ? SEC_SKIP : SEC_DONE;
							end
						end
					end
				end
				SEC_ABBR: begin
					body_v             = 1'b1;
					body_r.record_kind = KIND_ABBR;
					body_r.abbr_char   = b;
					ent_d              = ent_inc;
					if (WORD_W'(ent_inc) >= ccnt_q) begin
						ent_d  = '0;
						lane_d = '0;
						sec_d  = (skip_q != '0) ? SEC_SKIP : SEC_DONE;
					end
				end
				SEC_SKIP: begin
					if (skip_q != '0) begin
						skip_d = skip_q - 1'b1;
					end
					if (skip_q <= SKIP_W'(1)) begin
						sec_d = SEC_DONE;
					end
				end
				SEC_DONE: begin
				end
				default: begin
				end
			endcase
		end

		ok = !rej_d && sec_d == SEC_DONE;
		verdict_r                  = '0;
		verdict_r.record_kind      = KIND_VERDICT;
		verdict_r.accepted         = ok;
		verdict_r.transition_total = ok ? 11'(tcnt_q) : '0;
		verdict_r.type_total       = ok ? 9'(kcnt_q) : '0;
		verdict_r.abbr_total       = ok ? 9'(ccnt_q) : '0;
		verdict_r.run_end          = 1'b1;

		// end of file: back to the start state for the next file
		if (fin) begin
			sec_d  = SEC_HEADER;
			pos_d  = '0;
			word_d = '0;
			tcnt_d = '0;
			kcnt_d = '0;
			ccnt_d = '0;
			skip_d = '0;
			ent_d  = '0;
			lane_d = '0;
			dst_d  = 1'b0;
			rej_d  = 1'b0;
		end

		push.first_valid  = advance && (body_v || fin);
		push.first        = body_v ? body_r : verdict_r;
		push.second_valid = advance && body_v && fin;
		push.second       = verdict_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= SEC_HEADER;
			pos_q  <= '0;
			word_q <= '0;
			tcnt_q <= '0;
			kcnt_q <= '0;
			ccnt_q <= '0;
			skip_q <= '0;
			ent_q  <= '0;
			lane_q <= '0;
			dst_q  <= 1'b0;
			rej_q  <= 1'b0;
		end else if (advance) begin
			sec_q  <= sec_d;
			pos_q  <= pos_d;
			word_q <= word_d;
			tcnt_q <= tcnt_d;
			kcnt_q <= kcnt_d;
			ccnt_q <= ccnt_d;
			skip_q <= skip_d;
			ent_q  <= ent_d;
			lane_q <= lane_d;
			dst_q  <= dst_d;
			rej_q  <= rej_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/tzifp_outq.sv -----
// result queue taking up to two records per cycle and sending one per cycle while result_stall is low
`default_nettype none

module tzifp_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tzifp_pkg::push_t push,
	output logic                  room,
	output logic                  result_valid,
	output tzifp_pkg::result_t    result,
	input  wire logic             result_stall
);
	import tzifp_pkg::*;

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W-1:0] npush;
	logic              pop;

	assign npush        = QCNT_W'(push.first_valid) + QCNT_W'(push.second_valid);
	assign pop          = result_valid && !result_stall;
	assign result_valid = (count_q != '0);
	assign result       = mem_q[rd_q];
	assign room         = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.first_valid) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.second_valid) begin
			mem_q[QPTR_W'(wr_q + 1'b1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(npush);
			count_q <= count_q + npush - QCNT_W'(pop);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/tzif_v1_stream_parser_top.sv -----
// top level of the tzif v1 stream parser
//
//   channel  direction  payload    handshake
//   item     in         item_t     item_valid / item_stall
//   result   out        result_t   result_valid / result_stall
//
// one byte per cycle while the result queue has room; a byte's records are formed from the input register
// the input register advances when the result queue has two free slots
// a final byte that completes a record gives two results, the record and the verdict, pushed together
// asynchronous reset returns to the start of a file, no clearing pass
// item_stall rises only while the result queue has fewer than two free slots
`default_nettype none

module tzif_v1_stream_parser_top #(
	parameter int MAX_TRANSITIONS = tzifp_pkg::DEF_MAX_TRANSITIONS,
	parameter int MAX_TYPES       = tzifp_pkg::DEF_MAX_TYPES,
	parameter int MAX_ABBR_CHARS  = tzifp_pkg::DEF_MAX_ABBR_CHARS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire tzifp_pkg::item_t item,
	output logic                  item_stall,
	output logic                  result_valid,
	output tzifp_pkg::result_t    result,
	input  wire logic             result_stall
);
	import tzifp_pkg::*;

	push_t push;
	logic  room;

	tzifp_parse #(
		.MAX_TRANSITIONS (MAX_TRANSITIONS),
		.MAX_TYPES       (MAX_TYPES),
		.MAX_ABBR_CHARS  (MAX_ABBR_CHARS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.room       (room),
		.push       (push)
	);

	tzifp_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

endmodule

`default_nettype wire
